/* sv/quadrature_counter_with_homing_macros.svh */
// Assertion macros for the quadrature counter block
`ifndef QUADRATURE_COUNTER_WITH_HOMING_MACROS_SVH
`define QUADRATURE_COUNTER_WITH_HOMING_MACROS_SVH

`ifndef ASSERT_OFF
`define QCWH_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define QCWH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define QCWH_ASSERT(lbl, cond, msg)
`define QCWH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* sv/qcwh_pkg.sv */
// Types and constants for the quadrature counter with homing
`timescale 1ns / 1ps
`default_nettype none
package qcwh_pkg;

	typedef enum logic {
		REG_PRESET = 1'b0,
		REG_SCALE  = 1'b1
	} cfg_reg_t;

	localparam logic signed [31:0] PRESET_RESET = 32'sd100;
	localparam logic [15:0]        SCALE_RESET  = 16'd100;

	// tolerance on |preset - count| * scale
	localparam logic [47:0] MISMATCH_LIMIT = 48'd100000;

	// length saturates once count * scale reaches 65536 * 10000
	localparam logic [46:0] LENGTH_SAT = 47'd655360000;
	localparam logic [15:0] LENGTH_MAX = 16'hFFFF;

	// floor(p / 10000) = ((p >> 4) * RECIP) >> RECIP_SHIFT, exact for p < 2^30
	localparam logic [26:0] RECIP       = 27'd109951163;
	localparam int          RECIP_SHIFT = 36;

endpackage
`default_nettype wire

/* sv/quadrature_counter_with_homing.sv */
// Quadrature x4 decoder with reference-switch homing and length conversion
// Throughput: one sample per cycle while the output is not stalled; the count/direction
// update is a loop closed through the count registers, and the two multiplies and the
// reciprocal division run in the following stages. Stalls collapse bubbles, so samples
// keep being taken while a result waits, until every stage is full. Reset clears the count,
// direction, previous sample and pipeline; preset and scale return to 100.
`timescale 1ns / 1ps
`default_nettype none
`include "quadrature_counter_with_homing_macros.svh"
module quadrature_counter_with_homing (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_addr,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // chan_a, chan_b, ref_switch, zero pad
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata    // position[31:0], moving_up, both_changed_error,
	                                    // preset_applied, mismatch_error, length[15:0], pad
);

	logic signed [31:0] preset_q;
	logic [15:0]        scale_q;
	logic [2:0]         prev_q;
	logic signed [31:0] count_q;
	logic               up_q;
	logic               primed_q;

	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic s_accept;

	// step logic
	logic [2:0]         now;
	logic [2:0]         delta;
	logic               differ;
	logic signed [31:0] stepped;
	logic               up_next;
	logic               both_err;
	logic               hit;
	logic signed [31:0] count_next;

	// pipeline payload
	logic signed [31:0] count_s1, step_s1;
	logic               up_s1, both_s1, hit_s1;
	logic signed [31:0] count_s2, diff_s2;
	logic [46:0]        p_s2;
	logic               up_s2, both_s2, hit_s2;
	logic signed [31:0] count_s3;
	logic [31:0]        mag_s3;
	logic [52:0]        qprod_s3;
	logic               sat_s3, up_s3, both_s3, hit_s3;
	logic signed [31:0] count_s4;
	logic [47:0]        mprod_s4;
	logic [15:0]        len_s4;
	logic               up_s4, both_s4, hit_s4;
	logic signed [31:0] count_s5;
	logic [15:0]        len_s5;
	logic               up_s5, both_s5, hit_s5, mis_s5;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preset_q <= qcwh_pkg::PRESET_RESET;
			scale_q  <= qcwh_pkg::SCALE_RESET;
		end else if (cfg_we) begin
			unique case (qcwh_pkg::cfg_reg_t'(cfg_addr))
				qcwh_pkg::REG_PRESET: preset_q <= cfg_wdata;
				qcwh_pkg::REG_SCALE:  scale_q  <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// bubble-collapsing stage enables
	assign en_s5    = !v_s5 || m_tready;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;
	assign s_accept = s_tvalid && s_tready;

	always_comb begin
		now     = s_tdata[2:0];
		delta   = now ^ prev_q;
		differ  = now[0] ^ now[1];
		stepped = count_q;
		up_next = up_q;
		both_err = 1'b0;
		unique case (delta[1:0])
			2'b01: begin
				stepped = differ ? count_q - 32'sd1 : count_q + 32'sd1;
				up_next = !differ;
			end
			2'b10: begin
				stepped = differ ? count_q + 32'sd1 : count_q - 32'sd1;
				up_next = differ;
			end
			2'b11: both_err = 1'b1;
			default: ;
		endcase
		if (!primed_q) begin
			stepped  = count_q;
			up_next  = up_q;
			both_err = 1'b0;
		end
		// falling reference edge while moving up
		hit        = primed_q && delta[2] && up_next && !now[2];
		count_next = hit ? preset_q : stepped;
	end

	// count state, advanced once per accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= 3'b000;
			count_q  <= 32'sd0;
			up_q     <= 1'b0;
			primed_q <= 1'b0;
		end else if (s_accept) begin
			prev_q   <= now;
			count_q  <= count_next;
			up_q     <= up_next;
			primed_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			count_s1 <= count_next;
			step_s1  <= stepped;
			up_s1    <= up_next;
			both_s1  <= both_err;
			hit_s1   <= hit;
		end
		if (en_s2 && v_s1) begin
			count_s2 <= count_s1;
			diff_s2  <= preset_q - step_s1;
			p_s2     <= count_s1[31] ? 47'd0 : 47'(count_s1[30:0]) * 47'(scale_q);
			up_s2    <= up_s1;
			both_s2  <= both_s1;
			hit_s2   <= hit_s1;
		end
		if (en_s3 && v_s2) begin
			count_s3 <= count_s2;
			// negating the most negative difference yields 2^31 as unsigned
			mag_s3   <= diff_s2[31] ? 32'd0 - 32'(diff_s2) : 32'(diff_s2);
			sat_s3   <= p_s2 >= qcwh_pkg::LENGTH_SAT;
			qprod_s3 <= 53'(p_s2[29:4]) * 53'(qcwh_pkg::RECIP);
			up_s3    <= up_s2;
			both_s3  <= both_s2;
			hit_s3   <= hit_s2;
		end
		if (en_s4 && v_s3) begin
			count_s4 <= count_s3;
			mprod_s4 <= 48'(mag_s3) * 48'(scale_q);
			len_s4   <= sat_s3 ? qcwh_pkg::LENGTH_MAX
			                   : qprod_s3[qcwh_pkg::RECIP_SHIFT +: 16];
			up_s4    <= up_s3;
			both_s4  <= both_s3;
			hit_s4   <= hit_s3;
		end
		if (en_s5 && v_s4) begin
			count_s5 <= count_s4;
			len_s5   <= len_s4;
			up_s5    <= up_s4;
			both_s5  <= both_s4;
			hit_s5   <= hit_s4;
			mis_s5   <= hit_s4 && (mprod_s4 > qcwh_pkg::MISMATCH_LIMIT);
		end
	end

	assign m_tvalid = v_s5;
	assign m_tdata  = {4'b0000, len_s5, mis_s5, hit_s5, both_s5, up_s5, count_s5};

	`QCWH_ASSERT_NEXT(a_preset_load, s_accept && hit, count_q == $past(preset_q), "preset not loaded")
	`QCWH_ASSERT_NEXT(a_both_hold, s_accept && both_err && !hit, count_q == $past(count_q), "count moved on double change")
	`QCWH_ASSERT(a_mismatch_hit, !(v_s5 && mis_s5) || hit_s5, "mismatch without preset")
	`QCWH_ASSERT(a_neg_length, !(v_s5 && count_s5[31]) || (len_s5 == 16'd0), "length of negative count")

endmodule
`default_nettype wire
